/* rtl/spw_pkg.sv */
package spw_pkg;

  // Size limits of the frame buffer
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_SCALE  = 8;

  // Field and register widths
  localparam int DIM_W      = 9;
  localparam int SCALE_W    = 4;
  localparam int COORD_W    = 8;
  localparam int COLOR_W    = 8;
  localparam int INDEX_W    = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Datapath widths
  localparam int STRIDE_W = DIM_W + SCALE_W;
  localparam int COLB_W   = COORD_W + SCALE_W;
  localparam int STEP_W   = STRIDE_W + SCALE_W;
  localparam int PROD_W   = STEP_W + DIM_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_X_SCALE,
    REG_Y_SCALE,
    REG_BG_RED,
    REG_BG_GREEN,
    REG_BG_BLUE
  } spw_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } spw_rgb_t;

  // Clamped configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [SCALE_W-1:0] xs;
    logic [SCALE_W-1:0] ys;
    spw_rgb_t           bg;
  } spw_cfg_t;

  // One block job handed from the address pipeline to the beat generator
  typedef struct packed {
    logic [INDEX_W-1:0]  row_base;
    logic [STRIDE_W-1:0] stride;
    logic [SCALE_W-1:0]  xs;
    logic [SCALE_W-1:0]  ys;
    spw_rgb_t            color;
  } spw_job_t;

endpackage

/* rtl/spw_front.sv */
module spw_front
  import spw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  spw_cfg_t           cfg,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [COORD_W-1:0] in_pos_x,
  input  logic [COORD_W-1:0] in_pos_y,
  input  logic [COLOR_W-1:0] in_red,
  input  logic [COLOR_W-1:0] in_green,
  input  logic [COLOR_W-1:0] in_blue,
  output logic               job_valid,
  input  logic               job_ready,
  output spw_job_t           job
);

  logic accept;
  logic keep;
  logic s1_free, s2_free, s3_free, s4_free;

  // stage 1: request capture
  logic               s1_v_r;
  logic [COORD_W-1:0] s1_px_r;
  logic [COORD_W-1:0] s1_py_r;
  spw_rgb_t           s1_rgb_r;

  // stage 2: stride, column base, flipped row
  logic                s2_v_r;
  logic [STRIDE_W-1:0] s2_stride_r;
  logic [COLB_W-1:0]   s2_colb_r;
  logic [DIM_W-1:0]    s2_rowy_r;
  spw_rgb_t            s2_rgb_r;

  // stage 3: bytes-free row step of one logical row
  logic                s3_v_r;
  logic [STEP_W-1:0]   s3_step_r;
  logic [STRIDE_W-1:0] s3_stride_r;
  logic [COLB_W-1:0]   s3_colb_r;
  logic [DIM_W-1:0]    s3_rowy_r;
  spw_rgb_t            s3_rgb_r;

  // stage 4: first pixel of the block
  logic                s4_v_r;
  spw_job_t            s4_job_r;

  spw_rgb_t in_rgb;

  // Out-of-range or zero-sized requests never enter the pipe
  assign keep = (cfg.xs != '0) && (cfg.ys != '0) &&
                (DIM_W'(in_pos_x) < cfg.w) && (DIM_W'(in_pos_y) < cfg.h);

  // Stall chain from the generator back to the input
  assign s4_free = !s4_v_r || job_ready;
  assign s3_free = !s3_v_r || s4_free;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_free = !s1_v_r || s2_free;
  assign busy    = !s1_free;
  assign accept  = start && !busy;

  always_comb begin
    in_rgb.red   = in_red;
    in_rgb.green = in_green;
    in_rgb.blue  = in_blue;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_free) s1_v_r <= accept && keep;
      if (s2_free) s2_v_r <= s1_v_r;
      if (s3_free) s3_v_r <= s2_v_r;
      if (s4_free) s4_v_r <= s3_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_px_r  <= in_pos_x;
      s1_py_r  <= in_pos_y;
      s1_rgb_r <= in_op ? cfg.bg : in_rgb;
    end
    if (s2_free) begin
      s2_stride_r <= STRIDE_W'(cfg.xs) * STRIDE_W'(cfg.w);
      s2_colb_r   <= COLB_W'(cfg.xs) * COLB_W'(s1_px_r);
      s2_rowy_r   <= cfg.h - DIM_W'(1) - DIM_W'(s1_py_r);
      s2_rgb_r    <= s1_rgb_r;
    end
    if (s3_free) begin
      s3_step_r   <= STEP_W'(s2_stride_r) * STEP_W'(cfg.ys);
      s3_stride_r <= s2_stride_r;
      s3_colb_r   <= s2_colb_r;
      s3_rowy_r   <= s2_rowy_r;
      s3_rgb_r    <= s2_rgb_r;
    end
    if (s4_free) begin
      s4_job_r.row_base <= INDEX_W'(PROD_W'(s3_step_r) * PROD_W'(s3_rowy_r)
                                    + PROD_W'(s3_colb_r));
      s4_job_r.stride   <= s3_stride_r;
      s4_job_r.xs       <= cfg.xs;
      s4_job_r.ys       <= cfg.ys;
      s4_job_r.color    <= s3_rgb_r;
    end
  end

  assign job_valid = s4_v_r;
  assign job       = s4_job_r;

endmodule

/* rtl/spw_gen.sv */
module spw_gen
  import spw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  spw_job_t           job,
  output logic               out_valid,
  output logic [INDEX_W-1:0] out_pixel_index,
  output logic [COLOR_W-1:0] out_blue,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_red,
  output logic               out_last
);

  // Walk state
  logic                act_r;
  logic [INDEX_W-1:0]  row_addr_r;
  logic [SCALE_W-1:0]  col_r;
  logic [SCALE_W-1:0]  rows_r;
  logic [SCALE_W-1:0]  xs_r;
  logic [INDEX_W-1:0]  stride_r;
  spw_rgb_t            rgb_r;

  // Output beat register
  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_index_r;
  spw_rgb_t            out_rgb_r;
  logic                out_last_r;

  logic done;

  assign done      = (col_r == '0) && (rows_r == '0);
  assign job_ready = !act_r || done;

  // Columns right to left, rows upward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (job_ready) begin
      act_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) begin
      row_addr_r <= job.row_base;
      col_r      <= job.xs - SCALE_W'(1);
      rows_r     <= job.ys - SCALE_W'(1);
      xs_r       <= job.xs;
      stride_r   <= INDEX_W'(job.stride);
      rgb_r      <= job.color;
    end else if (col_r == '0) begin
      rows_r     <= rows_r - SCALE_W'(1);
      col_r      <= xs_r - SCALE_W'(1);
      row_addr_r <= row_addr_r + stride_r;
    end else begin
      col_r      <= col_r - SCALE_W'(1);
    end
  end

  // One beat per active cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r <= row_addr_r + INDEX_W'(col_r);
    out_rgb_r   <= rgb_r;
    out_last_r  <= done;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_index_r;
  assign out_blue        = out_rgb_r.blue;
  assign out_green       = out_rgb_r.green;
  assign out_red         = out_rgb_r.red;
  assign out_last        = out_valid_r && out_last_r;

endmodule

/* rtl/scaled_pixel_plot_writer_unit.sv */
// Scaled pixel plot writer: paints one logical pixel as an x_scale by y_scale
// block of a bottom-up 24-bit frame buffer.
// Input: a request beat (op, position, colour) is taken on a clock edge with
// start high and busy low. Out-of-range or zero-sized requests are taken and
// dropped at once, giving no writes.
// Output: one frame-buffer write per cycle on out_*, marked by out_valid for
// one cycle; out_last flags the final write of a block. The receiver cannot
// stall, so writes leave at a fixed rate.
// Path: after the accepting edge a request passes three more address stages,
// the generator load and the output register before its first write appears.
// Occupancy: a request occupies the write generator for its x_scale*y_scale
// writes (up to 64); the address pipeline holds further requests meanwhile and
// busy rises when it is full. Consecutive blocks stream with no gap.
// Configuration: cfg_we writes register cfg_index; write only while idle.
// Reset (synchronous, rst_n low) empties the pipeline and generator and loads
// width 128, height 64, scales 1 and a black background.
module scaled_pixel_plot_writer_unit
  import spw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [COORD_W-1:0]    in_pos_x,
  input  logic [COORD_W-1:0]    in_pos_y,
  input  logic [COLOR_W-1:0]    in_red,
  input  logic [COLOR_W-1:0]    in_green,
  input  logic [COLOR_W-1:0]    in_blue,
  output logic                  out_valid,
  output logic [INDEX_W-1:0]    out_pixel_index,
  output logic [COLOR_W-1:0]    out_blue,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_red,
  output logic                  out_last
);

  logic [DIM_W-1:0]   grid_width_r;
  logic [DIM_W-1:0]   grid_height_r;
  logic [SCALE_W-1:0] x_scale_r;
  logic [SCALE_W-1:0] y_scale_r;
  logic [COLOR_W-1:0] bg_red_r;
  logic [COLOR_W-1:0] bg_green_r;
  logic [COLOR_W-1:0] bg_blue_r;

  spw_cfg_t cfg;
  logic     job_valid;
  logic     job_ready;
  spw_job_t job;

  // Register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(128);
      grid_height_r <= DIM_W'(64);
      x_scale_r     <= SCALE_W'(1);
      y_scale_r     <= SCALE_W'(1);
      bg_red_r      <= '0;
      bg_green_r    <= '0;
      bg_blue_r     <= '0;
    end else if (cfg_we) begin
      unique case (spw_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_data[DIM_W-1:0];
        REG_X_SCALE:     x_scale_r     <= cfg_data[SCALE_W-1:0];
        REG_Y_SCALE:     y_scale_r     <= cfg_data[SCALE_W-1:0];
        REG_BG_RED:      bg_red_r      <= cfg_data[COLOR_W-1:0];
        REG_BG_GREEN:    bg_green_r    <= cfg_data[COLOR_W-1:0];
        REG_BG_BLUE:     bg_blue_r     <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes and scales to the buffer limits
  always_comb begin
    cfg.w = (32'(grid_width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : grid_width_r;
    cfg.h = (32'(grid_height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : grid_height_r;
    cfg.xs = (32'(x_scale_r) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : x_scale_r;
    cfg.ys = (32'(y_scale_r) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : y_scale_r;
    cfg.bg.red   = bg_red_r;
    cfg.bg.green = bg_green_r;
    cfg.bg.blue  = bg_blue_r;
  end

  spw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .busy      (busy),
    .in_op     (in_op),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  spw_gen u_gen (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job             (job),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_blue        (out_blue),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_last        (out_last)
  );

  // No write beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("write beat after reset");

  // A block streams without gaps until its last beat
  a_block_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a block");

  // A job held by a busy generator does not change
  a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("pending job lost or changed");

endmodule

/* dv/tb_scaled_pixel_plot_writer_unit.sv */
module tb_scaled_pixel_plot_writer_unit;
  import spw_pkg::*;

  // Cycles to let the address pipeline empty before touching the registers
  localparam int unsigned SETTLE_CYCLES = 16;
  // Cycles with no beat on any port before the run is declared hung
  localparam int unsigned STALL_LIMIT   = 1000;
  // Writing items per random phase, and number of random phases
  localparam int unsigned RAND_ITEMS    = 34;
  localparam int unsigned RAND_PHASES   = 8;
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum logic {
    OP_COLOR      = 1'b0,
    OP_BACKGROUND = 1'b1
  } plot_op_t;

  // One plot request; drain_first holds it back until all writes are out
  typedef struct {
    plot_op_t           op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    bit                 drain_first;
  } plot_req_t;

  // One frame-buffer write
  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               last;
  } fb_write_t;

  // Raw register contents as the block holds them
  typedef struct {
    logic [DIM_W-1:0]   grid_width;
    logic [DIM_W-1:0]   grid_height;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [COLOR_W-1:0] bg_red;
    logic [COLOR_W-1:0] bg_green;
    logic [COLOR_W-1:0] bg_blue;
  } plot_regs_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  start     = 1'b0;
  logic                  busy;
  logic                  in_op     = 1'b0;
  logic [COORD_W-1:0]    in_pos_x  = '0;
  logic [COORD_W-1:0]    in_pos_y  = '0;
  logic [COLOR_W-1:0]    in_red    = '0;
  logic [COLOR_W-1:0]    in_green  = '0;
  logic [COLOR_W-1:0]    in_blue   = '0;
  logic                  out_valid;
  logic [INDEX_W-1:0]    out_pixel_index;
  logic [COLOR_W-1:0]    out_blue;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_red;
  logic                  out_last;

  plot_regs_t  shadow_regs;
  plot_req_t   pending_reqs[$];
  fb_write_t   expected_writes[$];
  plot_req_t   cur_req;
  fb_write_t   seen_write;
  fb_write_t   want_write;
  int unsigned gap_left     = 0;
  bit          steady       = 1'b0;
  int unsigned write_errors = 0;
  int unsigned quiet_cycles = 0;

  scaled_pixel_plot_writer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_blue        (out_blue),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_last        (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  // Block size of a request under the shadow registers; with commit set,
  // also queue its writes: rows upward, columns right to left
  function automatic int unsigned paint_block(plot_req_t r, bit commit);
    int unsigned w, h, xs, ys, total, stride, row_base, n, sy, sx, px, py;
    fb_write_t   wr;
    w  = clamp_to(32'(shadow_regs.grid_width), MAX_WIDTH);
    h  = clamp_to(32'(shadow_regs.grid_height), MAX_HEIGHT);
    xs = clamp_to(32'(shadow_regs.x_scale), MAX_SCALE);
    ys = clamp_to(32'(shadow_regs.y_scale), MAX_SCALE);
    px = 32'(r.pos_x);
    py = 32'(r.pos_y);
    if (xs == 0 || ys == 0 || px >= w || py >= h) return 0;
    total = xs * ys;
    if (!commit) return total;
    if (r.op == OP_BACKGROUND) begin
      wr.red   = shadow_regs.bg_red;
      wr.green = shadow_regs.bg_green;
      wr.blue  = shadow_regs.bg_blue;
    end else begin
      wr.red   = r.red;
      wr.green = r.green;
      wr.blue  = r.blue;
    end
    stride   = xs * w;
    row_base = xs * px + stride * ys * (h - 1 - py);
    n = 0;
    for (sy = 0; sy < ys; sy++) begin
      for (sx = xs; sx != 0; sx--) begin
        n++;
        wr.pixel_index = INDEX_W'(row_base + sx - 1);
        wr.last        = (n == total);
        expected_writes.push_back(wr);
      end
      row_base += stride;
    end
    return total;
  endfunction

  // Idle length before the next request: mostly none, some short, a few long
  function automatic int unsigned next_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) void'(paint_block(cur_req, 1'b1));
      if ($urandom_range(0, 49) == 0) steady <= !steady;
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && expected_writes.size() != 0)) begin
        cur_req = pending_reqs.pop_front();
        in_op    <= cur_req.op;
        in_pos_x <= cur_req.pos_x;
        in_pos_y <= cur_req.pos_y;
        in_red   <= cur_req.red;
        in_green <= cur_req.green;
        in_blue  <= cur_req.blue;
        start    <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Write monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_write = '{out_pixel_index, out_blue, out_green, out_red, out_last};
      if (expected_writes.size() == 0) begin
        if (write_errors < 10)
          $display("tb: unexpected write idx=%0d bgr=%h/%h/%h last=%b",
                   out_pixel_index, out_blue, out_green, out_red, out_last);
        write_errors++;
      end else begin
        want_write = expected_writes.pop_front();
        if (seen_write.pixel_index !== want_write.pixel_index ||
            seen_write.blue !== want_write.blue ||
            seen_write.green !== want_write.green ||
            seen_write.red !== want_write.red ||
            seen_write.last !== want_write.last) begin
          if (write_errors < 10)
            $display("tb: mismatch exp idx=%0d bgr=%h/%h/%h last=%b, ",
                     want_write.pixel_index, want_write.blue, want_write.green,
                     want_write.red, want_write.last,
                     "got idx=%0d bgr=%h/%h/%h last=%b",
                     seen_write.pixel_index, seen_write.blue, seen_write.green,
                     seen_write.red, seen_write.last);
          write_errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat anywhere
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // One register write, mirrored into the shadow copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_GRID_WIDTH:  shadow_regs.grid_width  = val;
      REG_GRID_HEIGHT: shadow_regs.grid_height = val;
      REG_X_SCALE:     shadow_regs.x_scale     = val[SCALE_W-1:0];
      REG_Y_SCALE:     shadow_regs.y_scale     = val[SCALE_W-1:0];
      REG_BG_RED:      shadow_regs.bg_red      = val[COLOR_W-1:0];
      REG_BG_GREEN:    shadow_regs.bg_green    = val[COLOR_W-1:0];
      REG_BG_BLUE:     shadow_regs.bg_blue     = val[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                            input logic [CFG_DATA_W-1:0] xs, input logic [CFG_DATA_W-1:0] ys,
                            input logic [CFG_DATA_W-1:0] br, input logic [CFG_DATA_W-1:0] bgn,
                            input logic [CFG_DATA_W-1:0] bb);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_X_SCALE, xs);
    write_reg(REG_Y_SCALE, ys);
    write_reg(REG_BG_RED, br);
    write_reg(REG_BG_GREEN, bgn);
    write_reg(REG_BG_BLUE, bb);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every request is taken and every write seen, then let the
  // pipeline empty of requests that give no writes
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_req(input plot_op_t op,
                          input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                          input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                          input logic [COLOR_W-1:0] b, input bit drain);
    plot_req_t req;
    req.op          = op;
    req.pos_x       = x;
    req.pos_y       = y;
    req.red         = r;
    req.green       = g;
    req.blue        = b;
    req.drain_first = drain;
    pending_reqs.push_back(req);
  endtask

  initial begin
    plot_req_t   req;
    int unsigned ph, made, w_eff, h_eff;
    int unsigned rw, rh, rxs, rys;

    shadow_regs = '{128, 64, 1, 1, 0, 0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: in range, corner, and out of range on each axis
    push_req(OP_COLOR, 0, 0, 8'h12, 8'h34, 8'h56, 0);
    push_req(OP_BACKGROUND, 127, 63, 8'hff, 8'hff, 8'hff, 0);
    push_req(OP_COLOR, 128, 0, 8'hff, 8'h00, 8'hff, 0);
    push_req(OP_COLOR, 0, 64, 8'h00, 8'hff, 8'h00, 0);
    push_req(OP_COLOR, 255, 255, 8'hff, 8'hff, 8'hff, 0);

    // Largest grid and scale
    wait_idle();
    set_config(256, 256, 8, 8, 9'h0ff, 9'h000, 9'h0aa);
    push_req(OP_COLOR, 0, 0, 8'hff, 8'hff, 8'hff, 0);
    push_req(OP_COLOR, 255, 255, 8'h00, 8'h00, 8'h00, 1);
    push_req(OP_BACKGROUND, 255, 0, 8'h00, 8'h00, 8'h00, 0);
    push_req(OP_COLOR, 0, 255, 8'ha5, 8'h5a, 8'h3c, 0);

    // Oversized size and scale clamp; unused data bits set; unmapped index
    wait_idle();
    write_reg(REG_UNMAPPED, 9'h1ff);
    set_config(511, 300, 9'h1ff, 9'h019, 9'h155, 9'h1aa, 9'h1ff);
    push_req(OP_COLOR, 255, 255, 8'h01, 8'h80, 8'hfe, 0);
    push_req(OP_BACKGROUND, 0, 0, 8'h00, 8'h00, 8'h00, 0);

    // Smallest grid: only the origin paints
    wait_idle();
    set_config(1, 1, 1, 1, 9'h000, 9'h0ff, 9'h000);
    push_req(OP_COLOR, 0, 0, 8'h7f, 8'h80, 8'h01, 0);
    push_req(OP_BACKGROUND, 0, 0, 8'h00, 8'h00, 8'h00, 0);
    push_req(OP_COLOR, 1, 0, 8'hff, 8'hff, 8'hff, 0);
    push_req(OP_COLOR, 0, 1, 8'hff, 8'hff, 8'hff, 0);

    // Zero scale or zero size paints nothing
    wait_idle();
    set_config(16, 16, 0, 2, 9'h011, 9'h022, 9'h033);
    push_req(OP_COLOR, 3, 3, 8'h44, 8'h55, 8'h66, 0);
    wait_idle();
    set_config(16, 16, 3, 0, 9'h011, 9'h022, 9'h033);
    push_req(OP_BACKGROUND, 3, 3, 8'h44, 8'h55, 8'h66, 0);
    wait_idle();
    set_config(0, 0, 3, 3, 9'h011, 9'h022, 9'h033);
    push_req(OP_COLOR, 0, 0, 8'h44, 8'h55, 8'h66, 0);
    push_req(OP_BACKGROUND, 0, 0, 8'h44, 8'h55, 8'h66, 0);

    // Random phases: random settings, mostly in-range requests
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      rw  = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511) : $urandom_range(1, 256);
      rh  = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511) : $urandom_range(1, 256);
      rxs = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      rys = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      set_config(CFG_DATA_W'(rw), CFG_DATA_W'(rh),
                 CFG_DATA_W'(rxs | ($urandom_range(0, 31) << SCALE_W)),
                 CFG_DATA_W'(rys | ($urandom_range(0, 31) << SCALE_W)),
                 CFG_DATA_W'($urandom_range(0, 511)), CFG_DATA_W'($urandom_range(0, 511)),
                 CFG_DATA_W'($urandom_range(0, 511)));
      w_eff = clamp_to(32'(shadow_regs.grid_width), MAX_WIDTH);
      h_eff = clamp_to(32'(shadow_regs.grid_height), MAX_HEIGHT);
      made = 0;
      while (made < RAND_ITEMS) begin
        req.op = plot_op_t'($urandom_range(0, 1));
        if ($urandom_range(0, 4) != 0) begin
          req.pos_x = COORD_W'($urandom_range(0, w_eff - 1));
          req.pos_y = COORD_W'($urandom_range(0, h_eff - 1));
        end else begin
          req.pos_x = COORD_W'($urandom_range(0, 255));
          req.pos_y = COORD_W'($urandom_range(0, 255));
        end
        req.red         = COLOR_W'($urandom_range(0, 255));
        req.green       = COLOR_W'($urandom_range(0, 255));
        req.blue        = COLOR_W'($urandom_range(0, 255));
        req.drain_first = ($urandom_range(0, 39) == 0);
        if (paint_block(req, 1'b0) != 0) made++;
        pending_reqs.push_back(req);
      end
    end

    wait_idle();
    if (expected_writes.size() != 0)
      $display("tb: %0d writes never seen", expected_writes.size());
    if (write_errors == 0 && expected_writes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
